### rtl/smo_pkg.sv
// Shared types, constants and the microcode table of the spring-mass oscillator.
`default_nettype none

package smo_pkg;

    // Input commands.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_FORCE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_SPRING = 2'd0;
    localparam logic [1:0] REG_DAMP   = 2'd1;
    localparam logic [1:0] REG_MASS   = 2'd2;
    localparam logic [1:0] REG_STEP   = 2'd3;

    // Register reset values and the lower bound on stiffness and mass.
    localparam logic [25:0] RST_SPRING = 26'd65536;
    localparam logic [25:0] RST_DAMP   = 26'd6554;
    localparam logic [25:0] RST_MASS   = 26'd65536;
    localparam logic [31:0] RST_STEP   = 32'd89478;
    localparam logic [25:0] MIN_KM     = 26'd656;

    // Number of quotient bits produced by the divider loop.
    localparam int unsigned DIV_STEPS = 50;
    localparam logic [5:0]  DIV_COUNT = 6'(DIV_STEPS);

    // Cap on the velocity increment magnitude (2^49) and position limit.
    localparam logic [49:0]        DV_CAP    = 50'h2000000000000;
    localparam logic signed [52:0] POS_LIMIT = 53'sd167772160;

    // Multiplier operand A sources.
    localparam logic [1:0] MA_K   = 2'd0;
    localparam logic [1:0] MA_C   = 2'd1;
    localparam logic [1:0] MA_MLO = 2'd2;
    localparam logic [1:0] MA_MHI = 2'd3;

    // Multiplier operand B sources.
    localparam logic [1:0] MB_X   = 2'd0;
    localparam logic [1:0] MB_VLO = 2'd1;
    localparam logic [1:0] MB_VHI = 2'd2;
    localparam logic [1:0] MB_DT  = 2'd3;

    // Datapath operations.
    localparam logic [4:0] OP_NOP   = 5'd0;
    localparam logic [4:0] OP_LDFT  = 5'd1;
    localparam logic [4:0] OP_SUBSH = 5'd2;
    localparam logic [4:0] OP_SUB   = 5'd3;
    localparam logic [4:0] OP_ABS   = 5'd4;
    localparam logic [4:0] OP_PLO   = 5'd5;
    localparam logic [4:0] OP_PHI   = 5'd6;
    localparam logic [4:0] OP_DINIT = 5'd7;
    localparam logic [4:0] OP_DSTEP = 5'd8;
    localparam logic [4:0] OP_DV    = 5'd9;
    localparam logic [4:0] OP_VUPD  = 5'd10;
    localparam logic [4:0] OP_VABS  = 5'd11;
    localparam logic [4:0] OP_DMLO  = 5'd12;
    localparam logic [4:0] OP_DMHI  = 5'd13;
    localparam logic [4:0] OP_DX    = 5'd14;
    localparam logic [4:0] OP_XUPD  = 5'd15;
    localparam logic [4:0] OP_LDF   = 5'd16;
    localparam logic [4:0] OP_CLR   = 5'd17;

    // Sequencing codes.
    localparam logic [1:0] SQ_NEXT = 2'd0;
    localparam logic [1:0] SQ_LOOP = 2'd1;
    localparam logic [1:0] SQ_END  = 2'd2;
    localparam logic [1:0] SQ_EMIT = 2'd3;

    // Program entry points.
    localparam logic [4:0] ENTRY_FORCE = 5'd0;
    localparam logic [4:0] ENTRY_CLEAR = 5'd1;
    localparam logic [4:0] ENTRY_TICK  = 5'd2;

    typedef struct packed {
        logic [1:0] mul_a;
        logic [1:0] mul_b;
        logic [4:0] op;
        logic [1:0] seq;
        logic       cnt_load;
    } ctrl_t;

    typedef struct packed {
        logic [25:0] k;
        logic [25:0] c;
        logic [25:0] m;
        logic [31:0] dt;
    } cfg_t;

    localparam ctrl_t CTRL_IDLE = '{mul_a: MA_K, mul_b: MB_X, op: OP_NOP,
                                    seq: SQ_END, cnt_load: 1'b0};

    // Microcode table: one control word per program step.
    function automatic ctrl_t micro_rom(input logic [4:0] addr);
        ctrl_t w;
        w = CTRL_IDLE;
        case (addr)
            5'd0:  w = '{MA_K,   MB_X,   OP_LDF,   SQ_END,  1'b0};
            5'd1:  w = '{MA_K,   MB_X,   OP_CLR,   SQ_END,  1'b0};
            5'd2:  w = '{MA_K,   MB_X,   OP_LDFT,  SQ_NEXT, 1'b0};
            5'd3:  w = '{MA_C,   MB_VLO, OP_SUBSH, SQ_NEXT, 1'b0};
            5'd4:  w = '{MA_C,   MB_VHI, OP_SUBSH, SQ_NEXT, 1'b0};
            5'd5:  w = '{MA_K,   MB_X,   OP_SUB,   SQ_NEXT, 1'b0};
            5'd6:  w = '{MA_K,   MB_X,   OP_ABS,   SQ_NEXT, 1'b0};
            5'd7:  w = '{MA_MLO, MB_DT,  OP_NOP,   SQ_NEXT, 1'b0};
            5'd8:  w = '{MA_MHI, MB_DT,  OP_PLO,   SQ_NEXT, 1'b0};
            5'd9:  w = '{MA_K,   MB_X,   OP_PHI,   SQ_NEXT, 1'b0};
            5'd10: w = '{MA_K,   MB_X,   OP_DINIT, SQ_NEXT, 1'b1};
            5'd11: w = '{MA_K,   MB_X,   OP_DSTEP, SQ_LOOP, 1'b0};
            5'd12: w = '{MA_K,   MB_X,   OP_DV,    SQ_NEXT, 1'b0};
            5'd13: w = '{MA_K,   MB_X,   OP_VUPD,  SQ_NEXT, 1'b0};
            5'd14: w = '{MA_K,   MB_X,   OP_VABS,  SQ_NEXT, 1'b0};
            5'd15: w = '{MA_MLO, MB_DT,  OP_NOP,   SQ_NEXT, 1'b0};
            5'd16: w = '{MA_MHI, MB_DT,  OP_DMLO,  SQ_NEXT, 1'b0};
            5'd17: w = '{MA_K,   MB_X,   OP_DMHI,  SQ_NEXT, 1'b0};
            5'd18: w = '{MA_K,   MB_X,   OP_DX,    SQ_NEXT, 1'b0};
            5'd19: w = '{MA_K,   MB_X,   OP_XUPD,  SQ_NEXT, 1'b0};
            5'd20: w = '{MA_K,   MB_X,   OP_NOP,   SQ_EMIT, 1'b0};
            default: w = CTRL_IDLE;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/smo_datapath.sv
// Datapath of the oscillator: shared multiplier, accumulators, divider and state.
`default_nettype none

module smo_datapath
    import smo_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  ctrl_t              ctrl,
    input  cfg_t               cfg,
    input  wire signed [31:0]  force_in,
    output logic signed [28:0] position
);

    // Oscillator state.
    logic signed [28:0] pos_reg;
    logic signed [47:0] vel_reg;
    logic signed [31:0] force_reg;

    // Working registers of one tick.
    logic signed [65:0] prod_reg;
    logic signed [51:0] acc_reg;
    logic [51:0]        mag_reg;
    logic               neg_reg;
    logic [83:0]        p_reg;
    logic [33:0]        rem_reg;
    logic [49:0]        low_reg;
    logic               ovf_reg;

    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [65:0] prod_sh;
    logic [33:0]        divisor;
    logic [34:0]        trial;
    logic               trial_ge;
    logic [49:0]        q_capped;
    logic signed [52:0] vsum;
    logic signed [47:0] vel_next;
    logic signed [52:0] xsum;
    logic signed [28:0] pos_next;

    assign position = pos_reg;

    // Multiplier operand selection.
    always_comb
    begin
        case (ctrl.mul_a)
            MA_K:    op_a = $signed({7'b0, cfg.k});
            MA_C:    op_a = $signed({7'b0, cfg.c});
            MA_MLO:  op_a = $signed({1'b0, mag_reg[31:0]});
            MA_MHI:  op_a = $signed({13'b0, mag_reg[51:32]});
            default: op_a = '0;
        endcase
        case (ctrl.mul_b)
            MB_X:    op_b = $signed({{4{pos_reg[28]}}, pos_reg});
            MB_VLO:  op_b = $signed({9'b0, vel_reg[23:0]});
            MB_VHI:  op_b = $signed({{9{vel_reg[47]}}, vel_reg[47:24]});
            MB_DT:   op_b = $signed({1'b0, cfg.dt});
            default: op_b = '0;
        endcase
    end

    // Products are floored to Q.16 by an arithmetic shift.
    assign prod_sh = prod_reg >>> 24;

    // One restoring division step against 256 times the mass.
    assign divisor  = {cfg.m, 8'b0};
    assign trial    = {rem_reg, low_reg[49]};
    assign trial_ge = trial >= {1'b0, divisor};

    // Quotient limited to the increment cap.
    assign q_capped = (ovf_reg || (low_reg > DV_CAP)) ? DV_CAP : low_reg;

    // Velocity update with saturation to 48 bits.
    assign vsum = $signed({{5{vel_reg[47]}}, vel_reg}) + $signed({acc_reg[51], acc_reg});
    always_comb
    begin
        if (vsum[52:47] != {6{vsum[47]}})
        begin
            vel_next = vsum[52] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            vel_next = vsum[47:0];
        end
    end

    // Position update with clamping to plus or minus ten.
    assign xsum = $signed({{24{pos_reg[28]}}, pos_reg}) + $signed({acc_reg[51], acc_reg});
    always_comb
    begin
        if (xsum > POS_LIMIT)
        begin
            pos_next = POS_LIMIT[28:0];
        end
        else if (xsum < -POS_LIMIT)
        begin
            pos_next = 29'(-POS_LIMIT);
        end
        else
        begin
            pos_next = xsum[28:0];
        end
    end

    // State registers, written by the load, clear and update operations.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            vel_reg   <= '0;
            force_reg <= '0;
        end
        else
        begin
            case (ctrl.op)
                OP_LDF:  force_reg <= force_in;
                OP_CLR:
                begin
                    pos_reg   <= '0;
                    vel_reg   <= '0;
                    force_reg <= '0;
                end
                OP_VUPD: vel_reg <= vel_next;
                OP_XUPD: pos_reg <= pos_next;
                default: ;
            endcase
        end
    end

    // Working registers of the tick program.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        case (ctrl.op)
            OP_LDFT:  acc_reg <= 52'(force_reg);
            OP_SUBSH: acc_reg <= acc_reg - prod_sh[51:0];
            OP_SUB:   acc_reg <= acc_reg - prod_reg[51:0];
            OP_ABS:
            begin
                mag_reg <= acc_reg[51] ? 52'(-acc_reg) : acc_reg;
                neg_reg <= acc_reg[51];
            end
            OP_PLO:   p_reg <= {20'b0, prod_reg[63:0]};
            OP_PHI:   p_reg <= p_reg + {prod_reg[51:0], 32'b0};
            OP_DINIT:
            begin
                ovf_reg <= p_reg[83:50] >= divisor;
                rem_reg <= p_reg[83:50];
                low_reg <= p_reg[49:0];
            end
            OP_DSTEP:
            begin
                rem_reg <= trial_ge ? 34'(trial - {1'b0, divisor}) : trial[33:0];
                low_reg <= {low_reg[48:0], trial_ge};
            end
            OP_DV:    acc_reg <= neg_reg ? -$signed({2'b0, q_capped})
                                         : $signed({2'b0, q_capped});
            OP_VABS:
            begin
                mag_reg <= {4'b0, vel_reg[47] ? 48'(-vel_reg) : vel_reg};
                neg_reg <= vel_reg[47];
            end
            OP_DMLO:  p_reg <= {52'b0, prod_reg[63:32]};
            OP_DMHI:  p_reg <= p_reg + {20'b0, prod_reg[63:0]};
            OP_DX:    acc_reg <= neg_reg ? -$signed(p_reg[51:0]) : $signed(p_reg[51:0]);
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### rtl/spring_mass_oscillator_step.sv
// Top level of the spring-mass oscillator: configuration, microcode sequencer, handshakes.
`default_nettype none

// Channel   Handshake               Payload
// config    cfg_write               cfg_index[1:0], cfg_data[31:0]
// input     in_valid / in_stall     command[1:0], force_value[31:0]
// output    out_valid / out_stall   position_out[28:0]
//
// A tick runs its program from the transaction to the result in the output register;
// the divider loop of the microcode, one quotient bit per cycle over 50 bits, takes
// most of it. The next input transaction is taken only after the program has ended.
// A force load or a state clear runs one step.
// Reset restores the register defaults and zeroes the state; in_stall stays high
// while a program runs and a finished tick waits while an earlier result is stalled.

module spring_mass_oscillator_step
    import smo_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_write,
    input  wire [1:0]          cfg_index,
    input  wire [31:0]         cfg_data,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire [1:0]          command,
    input  wire signed [31:0]  force_value,
    output logic               out_valid,
    input  wire                out_stall,
    output logic signed [28:0] position_out
);

    cfg_t               cfg_reg;
    logic               busy_reg;
    logic [4:0]         step_reg;
    logic [5:0]         cnt_reg;
    logic               out_valid_reg;
    logic signed [28:0] position_out_reg;
    logic signed [31:0] force_in_reg;

    ctrl_t              ctrl;
    logic               accept;
    logic               emit_fire;
    logic signed [28:0] position;
    logic [25:0]        cfg_low26;

    assign in_stall     = busy_reg;
    assign out_valid    = out_valid_reg;
    assign position_out = position_out_reg;
    assign accept       = in_valid && !busy_reg;

    // Control word of the current step; idle steps do nothing.
    assign ctrl = busy_reg ? micro_rom(step_reg) : CTRL_IDLE;

    // The emit step completes once the output register is free.
    assign emit_fire = busy_reg && (ctrl.seq == SQ_EMIT) && (!out_valid_reg || !out_stall);

    // Configuration registers; stiffness and mass are raised to their minimum.
    assign cfg_low26 = cfg_data[25:0];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.k  <= RST_SPRING;
            cfg_reg.c  <= RST_DAMP;
            cfg_reg.m  <= RST_MASS;
            cfg_reg.dt <= RST_STEP;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SPRING: cfg_reg.k  <= (cfg_low26 < MIN_KM) ? MIN_KM : cfg_low26;
                REG_DAMP:   cfg_reg.c  <= cfg_low26;
                REG_MASS:   cfg_reg.m  <= (cfg_low26 < MIN_KM) ? MIN_KM : cfg_low26;
                REG_STEP:   cfg_reg.dt <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: dispatch on the command, then step through the program.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The output register fills on an emit and empties when its transaction completes.
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                case (command)
                    CMD_TICK:
                    begin
                        step_reg <= ENTRY_TICK;
                        busy_reg <= 1'b1;
                    end
                    CMD_FORCE:
                    begin
                        step_reg <= ENTRY_FORCE;
                        busy_reg <= 1'b1;
                    end
                    CMD_CLEAR:
                    begin
                        step_reg <= ENTRY_CLEAR;
                        busy_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            else if (busy_reg)
            begin
                if (ctrl.cnt_load)
                begin
                    cnt_reg <= DIV_COUNT;
                end
                case (ctrl.seq)
                    SQ_NEXT: step_reg <= step_reg + 5'd1;
                    SQ_LOOP:
                    begin
                        cnt_reg <= cnt_reg - 6'd1;
                        if (cnt_reg == 6'd1)
                        begin
                            step_reg <= step_reg + 5'd1;
                        end
                    end
                    SQ_END:  busy_reg <= 1'b0;
                    SQ_EMIT:
                    begin
                        if (emit_fire)
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                    default: busy_reg <= 1'b0;
                endcase
            end
        end
    end

    // Payload registers: latched force value and the result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            force_in_reg <= force_value;
        end
        if (emit_fire)
        begin
            position_out_reg <= position;
        end
    end

    smo_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cfg      (cfg_reg),
        .force_in (force_in_reg),
        .position (position)
    );

endmodule

`default_nettype wire

### sim/spring_mass_oscillator_step_tb.sv
// Self-checking testbench for the spring-mass oscillator step block.
`timescale 1ns / 100ps

module spring_mass_oscillator_step_tb
    import smo_pkg::*;
();

    // Run shape and timing.
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int DIRECTED_ROWS   = 25;
    localparam int SETTLE_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_AFTER      = 200;
    localparam int HOLD_CYCLES     = 400;
    localparam int MAX_REPORTS     = 40;

    // Command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Oscillator constants used by the position predictor.
    localparam logic [31:0]        DEF_SPRING    = 32'd65536;
    localparam logic [31:0]        DEF_DAMP      = 32'd6554;
    localparam logic [31:0]        DEF_MASS      = 32'd65536;
    localparam logic [31:0]        DEF_STEP      = 32'd89478;
    localparam logic [25:0]        KM_FLOOR      = 26'd656;
    localparam longint             VEL_TOP       = 64'sh7FFF_FFFF_FFFF;
    localparam longint             VEL_BOTTOM    = -VEL_TOP - 1;
    localparam longint             X_LIMIT       = 64'sd167772160;
    localparam logic [127:0]       DV_LIMIT      = 128'h2_0000_0000_0000;
    localparam logic signed [28:0] POS_OUT_LIMIT = 29'sd167772160;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    // One row of the directed table: an input transaction or a register write.
    typedef struct packed {
        row_kind_t          kind;
        logic [1:0]         code;
        logic [31:0]        data;
        logic               has_ref;
        logic signed [28:0] ref_pos;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [1:0]          cfg_index;
    logic [31:0]         cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          command;
    logic signed [31:0]  force_value;
    logic                out_valid;
    logic                out_stall;
    logic signed [28:0]  position_out;

    // Predictor copy of the registers and the oscillator state.
    logic [25:0] spring_k;
    logic [25:0] damping_c;
    logic [25:0] mass_m;
    logic [31:0] step_dt;
    longint      position_s;
    longint      velocity_s;
    longint      force_s;

    logic signed [28:0] expected_positions [$];
    stim_row_t          directed_rows [0:DIRECTED_ROWS-1];

    int errors = 0;
    int items_sent;
    int results_checked = 0;
    int settings_applied;
    int quiet_cycles = 0;
    bit calm;

    spring_mass_oscillator_step dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .force_value  (force_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .position_out (position_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    function automatic void reset_oscillator();
        spring_k   = DEF_SPRING[25:0];
        damping_c  = DEF_DAMP[25:0];
        mass_m     = DEF_MASS[25:0];
        step_dt    = DEF_STEP;
        position_s = 0;
        velocity_s = 0;
        force_s    = 0;
    endfunction

    // Register update as the block stores it: 26-bit fields, stiffness and mass floored.
    function automatic void apply_setting(input logic [1:0] idx, input logic [31:0] value);
        case (idx)
            REG_SPRING: spring_k  = (value[25:0] < KM_FLOOR) ? KM_FLOOR : value[25:0];
            REG_DAMP:   damping_c = value[25:0];
            REG_MASS:   mass_m    = (value[25:0] < KM_FLOOR) ? KM_FLOOR : value[25:0];
            REG_STEP:   step_dt   = value;
            default:    ;
        endcase
    endfunction

    // Advance the oscillator by one command; returns 1 when a position comes out.
    function automatic logic step_oscillator(input logic [1:0] cmd, input logic [31:0] data,
                                             output logic signed [28:0] pos_next);
        longint       spring_t;
        longint       vel_hi;
        longint       vel_lo;
        longint       damp_t;
        longint       total;
        longint       dv;
        longint       vel;
        longint       pos;
        logic [63:0]  force_mag;
        logic [63:0]  vel_mag;
        logic [127:0] product;
        logic [127:0] quotient;
        logic [127:0] travel;
        pos_next = '0;
        if (cmd == CMD_FORCE)
        begin
            force_s = longint'(signed'(data));
            return 1'b0;
        end
        if (cmd == CMD_CLEAR)
        begin
            position_s = 0;
            velocity_s = 0;
            force_s    = 0;
            return 1'b0;
        end
        if (cmd != CMD_TICK)
        begin
            return 1'b0;
        end

        // Net force in Q.16: held force minus spring and damping terms.
        spring_t = (longint'(spring_k) * position_s) >>> 24;
        vel_hi   = velocity_s >>> 24;
        vel_lo   = velocity_s - (vel_hi <<< 24);
        damp_t   = longint'(damping_c) * vel_hi + ((longint'(damping_c) * vel_lo) >>> 24);
        total    = force_s - spring_t - damp_t;

        // Velocity increment |F|*dt/(256*m), capped, then saturating add.
        force_mag = (total < 0) ? 64'(-total) : 64'(total);
        product   = 128'(force_mag) * 128'(step_dt);
        quotient  = product / 128'({mass_m, 8'b0});
        if (quotient > DV_LIMIT)
        begin
            quotient = DV_LIMIT;
        end
        dv  = (total < 0) ? -longint'(quotient[63:0]) : longint'(quotient[63:0]);
        vel = velocity_s + dv;
        if (vel > VEL_TOP)
        begin
            vel = VEL_TOP;
        end
        if (vel < VEL_BOTTOM)
        begin
            vel = VEL_BOTTOM;
        end
        velocity_s = vel;

        // Position moves by the new velocity times dt, then clamps to plus or minus ten.
        vel_mag = (vel < 0) ? 64'(-vel) : 64'(vel);
        travel  = (128'(vel_mag) * 128'(step_dt)) >> 32;
        pos     = (vel < 0) ? position_s - longint'(travel[63:0])
                            : position_s + longint'(travel[63:0]);
        if (pos > X_LIMIT)
        begin
            pos = X_LIMIT;
        end
        if (pos < -X_LIMIT)
        begin
            pos = -X_LIMIT;
        end
        position_s = pos;
        pos_next   = pos[28:0];
        return 1'b1;
    endfunction

    function automatic int idle_draw();
        return calm ? 0 : int'($urandom_range(0, 10));
    endfunction

    // Register value for a phase: fixed extremes first, then the defaults, then a mix of ranges.
    function automatic logic [31:0] pick_setting(input int phase, input logic [1:0] idx);
        logic [31:0] value;
        int unsigned mode;
        int unsigned corner;
        mode   = $urandom_range(0, 4);
        corner = $urandom_range(0, 5);
        value  = '0;
        if (phase == 0)
        begin
            value = (idx == REG_STEP) ? 32'd1 : 32'd0;
        end
        else if (phase == 1)
        begin
            value = 32'hFFFF_FFFF;
        end
        else if (phase == 2)
        begin
            case (idx)
                REG_SPRING: value = DEF_SPRING;
                REG_DAMP:   value = DEF_DAMP;
                REG_MASS:   value = DEF_MASS;
                default:    value = DEF_STEP;
            endcase
        end
        else if (idx == REG_STEP)
        begin
            case (mode)
                0, 1:    value = $urandom_range(1, 32'h0100_0000);
                2:       value = $urandom;
                3:       value = $urandom_range(0, 2000);
                default:
                begin
                    case (corner % 4)
                        0:       value = 32'd0;
                        1:       value = 32'd1;
                        2:       value = 32'h8000_0000;
                        default: value = 32'hFFFF_FFFF;
                    endcase
                end
            endcase
        end
        else
        begin
            case (mode)
                0, 1:    value = $urandom_range(656, 65536000);
                2:       value = $urandom;
                3:       value = $urandom_range(0, 2000);
                default:
                begin
                    case (corner)
                        0:       value = 32'd0;
                        1:       value = 32'd655;
                        2:       value = 32'd656;
                        3:       value = 32'd65536000;
                        4:       value = 32'h03FF_FFFF;
                        default: value = 32'hFFFF_FFFF;
                    endcase
                end
            endcase
        end
        return value;
    endfunction

    function automatic logic [31:0] pick_force();
        logic [31:0] value;
        case ($urandom_range(0, 3))
            0:       value = $urandom;
            1:       value = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            2:       value = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       value = 32'h7FFF_FFFF;
                    1:       value = 32'h8000_0000;
                    2:       value = 32'hFFFF_FFFF;
                    default: value = 32'h0000_0000;
                endcase
            end
        endcase
        return value;
    endfunction

    function automatic logic [1:0] pick_command();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            return CMD_TICK;
        end
        if (roll < 88)
        begin
            return CMD_FORCE;
        end
        if (roll < 94)
        begin
            return CMD_CLEAR;
        end
        return CMD_UNUSED;
    endfunction

    // Offer one input transaction after an idle gap and record its expected position.
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] data, input int gap,
                             input logic has_ref, input logic signed [28:0] ref_pos);
        logic signed [28:0] predicted;
        logic               emits;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        force_value <= data;
        do @(posedge clk); while (in_stall !== 1'b0);
        items_sent++;
        emits = step_oscillator(cmd, data, predicted);
        if (emits)
        begin
            expected_positions.insert(expected_positions.size(),
                                      has_ref ? ref_pos : predicted);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        apply_setting(idx, value);
        settings_applied++;
    endtask

    // Stop offering and wait for every expected position to arrive.
    task automatic drain_positions();
        in_valid <= 1'b0;
        while (expected_positions.size() != 0) @(posedge clk);
    endtask

    // Drain, then allow a force load or clear still in progress to finish.
    task automatic settle_block();
        drain_positions();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Compare each accepted position with the oldest expectation.
    always @(posedge clk)
    begin : check_positions
        logic signed [28:0] want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_checked = results_checked + 1;
            if (expected_positions.size() == 0)
            begin
                report_mismatch($sformatf("unexpected position %0d", position_out));
            end
            else
            begin
                want = expected_positions.pop_front();
                if (position_out !== want)
                begin
                    report_mismatch($sformatf("position_out %0d, expected %0d",
                                              position_out, want));
                end
            end
        end
    end

    // Count cycles in which no transaction of any kind happens.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("spring_mass_oscillator_step_tb: FAIL");
        $finish;
    end

    // Result side: stall each result for a drawn number of cycles, once for a long stretch.
    initial
    begin : result_sink
        int hold;
        bit held_long;
        held_long = 1'b0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = idle_draw();
            if (!held_long && results_checked >= HOLD_AFTER)
            begin
                hold      = HOLD_CYCLES;
                held_long = 1'b1;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                do @(posedge clk); while (out_valid !== 1'b1);
                repeat (hold - 1) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    initial
    begin : stimulus
        int phase;
        int n;
        items_sent       = 0;
        settings_applied = 0;
        calm             = 1'b0;
        rst_n            = 1'b0;
        cfg_write        = 1'b0;
        cfg_index        = REG_SPRING;
        cfg_data         = '0;
        in_valid         = 1'b0;
        command          = CMD_TICK;
        force_value      = '0;
        reset_oscillator();

        // Directed table: reset state, ignored command, clear, floors on stiffness and
        // mass, both force extremes with position clamping, velocity saturation,
        // zero step and the cap on the velocity increment.
        directed_rows = '{
            '{ROW_ITEM, CMD_TICK,   32'h0000_0000, 1'b1, 29'sd0},
            '{ROW_ITEM, CMD_FORCE,  32'h0000_0000, 1'b0, 29'sd0},
            '{ROW_ITEM, CMD_UNUSED, 32'h7FFF_FFFF, 1'b0, 29'sd0},
            '{ROW_ITEM, CMD_TICK,   32'h0000_0000, 1'b1, 29'sd0},
            '{ROW_ITEM, CMD_FORCE,  32'h0001_0000, 1'b0, 29'sd0},
            '{ROW_ITEM, CMD_TICK,   32'h0000_0000, 1'b0, 29'sd0},
            '{ROW_ITEM, CMD_TICK,   32'h0000_0000, 1'b0, 29'sd0},
            '{ROW_ITEM, CMD_CLEAR,  32'hFFFF_FFFF, 1'b0, 29'sd0},
            '{ROW_ITEM, CMD_TICK,   32'h0000_0000, 1'b1, 29'sd0},
            '{ROW_REG,  REG_SPRING, 32'h0000_0000, 1'b0, 29'sd0},
            '{ROW_REG,  REG_DAMP,   32'h0000_0000, 1'b0, 29'sd0},
            '{ROW_REG,  REG_MASS,   32'h0000_0000, 1'b0, 29'sd0},
            '{ROW_REG,  REG_STEP,   32'hFFFF_FFFF, 1'b0, 29'sd0},
            '{ROW_ITEM, CMD_FORCE,  32'h7FFF_FFFF, 1'b0, 29'sd0},
            '{ROW_ITEM, CMD_TICK,   32'h0000_0000, 1'b1, POS_OUT_LIMIT},
            '{ROW_ITEM, CMD_CLEAR,  32'h0000_0000, 1'b0, 29'sd0},
            '{ROW_ITEM, CMD_FORCE,  32'h8000_0000, 1'b0, 29'sd0},
            '{ROW_ITEM, CMD_TICK,   32'h0000_0000, 1'b1, -POS_OUT_LIMIT},
            '{ROW_ITEM, CMD_TICK,   32'h0000_0000, 1'b0, 29'sd0},
            '{ROW_ITEM, CMD_TICK,   32'h0000_0000, 1'b0, 29'sd0},
            '{ROW_REG,  REG_STEP,   32'h0000_0000, 1'b0, 29'sd0},
            '{ROW_ITEM, CMD_TICK,   32'h0000_0000, 1'b1, -POS_OUT_LIMIT},
            '{ROW_REG,  REG_DAMP,   32'hFFFF_FFFF, 1'b0, 29'sd0},
            '{ROW_REG,  REG_STEP,   32'hFFFF_FFFF, 1'b0, 29'sd0},
            '{ROW_ITEM, CMD_TICK,   32'h0000_0000, 1'b0, 29'sd0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_REG)
            begin
                settle_block();
                write_reg(directed_rows[r].code, directed_rows[r].data);
                cfg_write <= 1'b0;
            end
            else
            begin
                send_item(directed_rows[r].code, directed_rows[r].data, idle_draw(),
                          directed_rows[r].has_ref, directed_rows[r].ref_pos);
            end
        end

        // Random phases, each under its own register setting; two phases run without idling.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle_block();
            calm = (phase == 2 || phase == 6);
            write_reg(REG_SPRING, pick_setting(phase, REG_SPRING));
            write_reg(REG_DAMP, pick_setting(phase, REG_DAMP));
            write_reg(REG_MASS, pick_setting(phase, REG_MASS));
            write_reg(REG_STEP, pick_setting(phase, REG_STEP));
            cfg_write <= 1'b0;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Sender pause until the pipeline is empty, mid-phase.
                if (phase == 4 && n == ITEMS_PER_PHASE / 2)
                begin
                    drain_positions();
                end
                send_item(pick_command(), pick_force(), idle_draw(), 1'b0, 29'sd0);
            end
        end

        settle_block();
        $display("Covered %0d input transactions (%0d directed rows) and %0d positions,",
                 items_sent, DIRECTED_ROWS, results_checked);
        $display("under %0d register writes across %0d random phases; %0d mismatches.",
                 settings_applied, NUM_PHASES, errors);
        if (errors == 0)
        begin
            $display("spring_mass_oscillator_step_tb: PASS");
        end
        else
        begin
            $display("spring_mass_oscillator_step_tb: FAIL");
        end
        $finish;
    end

endmodule
